### hw/rtl/multicast_residue_scheduler_defines.svh
// Assertion macros shared by the multicast residue scheduler RTL.
`ifndef MULTICAST_RESIDUE_SCHEDULER_DEFINES_SVH
`define MULTICAST_RESIDUE_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("multicast residue scheduler: assertion failed");
`define MRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("multicast residue scheduler: assertion failed");
`else
`define MRS_ASSERT(lbl, prop)
`define MRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/mrs_pkg.sv
// Shared constants, types and helper functions of the multicast residue scheduler.
`timescale 1ns / 1ps
package mrs_pkg;
  localparam int NUM_INPUTS  = 16;
  localparam int NUM_OUTPUTS = 16;
  localparam int NUM_RES     = (NUM_OUTPUTS < 16) ? NUM_OUTPUTS : 16;
  localparam int IDX_W       = $clog2(NUM_INPUTS);
  localparam int OIDX_W      = $clog2(NUM_OUTPUTS);
  localparam int CNT_W       = (IDX_W > OIDX_W) ? IDX_W : OIDX_W;
  localparam int NT_W        = $clog2(NUM_INPUTS + 1);
  localparam int PC_W        = $clog2(NUM_OUTPUTS + 1);
  localparam int TOT_W       = $clog2(NUM_INPUTS * NUM_OUTPUTS + 1);
  localparam int AGE_W       = 32;
  localparam int LFSR_W      = 16;
  localparam int PORT_W      = 4;
  localparam int FAN_W       = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

  typedef logic [NUM_OUTPUTS-1:0] row_t;

  typedef struct packed {
    logic             load;
    logic             sched_clear;
    logic             init_acc;
    logic             fix;
    logic             scan_start;
    logic             scan_step;
    logic             clear_chosen;
    logic             pick_first;
    logic             mod_start;
    logic             pick_mod;
    logic             apply;
    logic             emit_load;
    logic [CNT_W-1:0] idx;
  } mrs_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic nties_zero;
    logic nties_one;
    logic mod_done;
  } mrs_sts_t;

  function automatic logic [PC_W-1:0] popcnt(input row_t row);
    logic [PC_W-1:0] n;
    n = '0;
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      n = n + PC_W'(row[k]);
    end
    return n;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction
endpackage

### hw/rtl/mrs_mod.sv
// Bit-serial remainder unit: LFSR value modulo the tie count, one bit per cycle.
`timescale 1ns / 1ps
module mrs_mod
  import mrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [NT_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  rem_o
);
  localparam int SC_W = $clog2(LFSR_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SC_W-1:0]   cnt_q, cnt_d;
  logic [LFSR_W-1:0] dvd_q, dvd_d;
  logic [NT_W-1:0]   dsr_q, dsr_d;
  logic [NT_W-1:0]   rem_q, rem_d;
  logic [NT_W:0]     shifted;
  logic [NT_W:0]     diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[LFSR_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits NT_W bits.
      rem_d = (shifted >= {1'b0, dsr_q}) ? diff[NT_W-1:0] : shifted[NT_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SC_W'(LFSR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];
endmodule

### hw/rtl/mrs_dp.sv
// Datapath: request and taken rows, residues, tie list, LFSR and result register.
`timescale 1ns / 1ps
module mrs_dp
  import mrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrs_cmd_t          cmd_i,
  output mrs_sts_t          sts_o,
  input  logic [PORT_W-1:0] port_index_i,
  input  logic              has_cell_i,
  input  logic [FAN_W-1:0]  fanout_map_i,
  input  logic [AGE_W-1:0]  cell_age_i,
  input  logic              cfg_we_i,
  input  logic [LFSR_W-1:0] cfg_lfsr_seed_i,
  output logic [3:0]        output_index_o,
  output logic              granted_o,
  output logic [3:0]        grant_port_o,
  output logic              last_grant_o
);
  row_t              req_q   [NUM_INPUTS];
  row_t              taken_q [NUM_INPUTS];
  logic [AGE_W-1:0]  age_q   [NUM_INPUTS];
  logic [NT_W-1:0]   resid_q [NUM_OUTPUTS];
  logic [IDX_W-1:0]  ties_q  [NUM_INPUTS];
  logic [TOT_W-1:0]  total_q;
  logic [NUM_INPUTS-1:0] chosen_q;
  logic [NT_W-1:0]   nties_q;
  logic [PC_W-1:0]   least_q;
  logic [AGE_W-1:0]  least_age_q;
  logic [IDX_W-1:0]  pick_q;
  logic [LFSR_W-1:0] lfsr_q;
  logic [3:0]        oidx_q;
  logic              granted_q;
  logic [3:0]        gport_q;
  logic              glast_q;

  row_t              live;
  logic [IDX_W-1:0]  in_idx;
  logic [OIDX_W-1:0] out_idx;
  row_t              scan_row;
  logic [PC_W-1:0]   common;
  logic [AGE_W-1:0]  scan_age;
  logic              qualify, better, equal;
  row_t              avail;
  logic [OIDX_W-1:0] low_bit;
  logic              col_hit;
  logic [IDX_W-1:0]  col_port;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;
  logic [LFSR_W-1:0] lfsr_adv;

  assign in_idx  = cmd_i.idx[IDX_W-1:0];
  assign out_idx = cmd_i.idx[OIDX_W-1:0];
  assign lfsr_adv = lfsr_next(lfsr_q);

  always_comb begin
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      live[o] = (resid_q[o] != '0);
    end
  end

  // One input per cycle is weighed against the best candidate so far.
  always_comb begin
    scan_row = req_q[in_idx] & ~taken_q[in_idx] & live;
    common   = popcnt(scan_row);
    scan_age = age_q[in_idx];
    qualify  = !chosen_q[in_idx] && (common != '0);
    better   = (nties_q == '0) || (common < least_q) ||
               ((common == least_q) && (scan_age < least_age_q));
    equal    = (common == least_q) && (scan_age == least_age_q);
  end

  always_comb begin
    avail   = req_q[pick_q] & ~taken_q[pick_q] & live;
    low_bit = '0;
    for (int o = NUM_OUTPUTS - 1; o >= 0; o--) begin
      if (avail[o]) begin
        low_bit = OIDX_W'(o);
      end
    end
  end

  always_comb begin
    col_hit  = 1'b0;
    col_port = '0;
    for (int k = 0; k < NUM_INPUTS; k++) begin
      if (req_q[k][out_idx] && !taken_q[k][out_idx]) begin
        col_hit  = 1'b1;
        col_port = IDX_W'(k);
      end
    end
  end

  mrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (lfsr_adv),
    .divisor_i  (nties_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        req_q[i]   <= '0;
        taken_q[i] <= '0;
      end
      for (int o = 0; o < NUM_OUTPUTS; o++) begin
        resid_q[o] <= '0;
      end
      total_q  <= '0;
      chosen_q <= '0;
      lfsr_q   <= LFSR_RESET;
    end else begin
      if (cfg_we_i) begin
        lfsr_q <= cfg_lfsr_seed_i;
      end
      if (cmd_i.load) begin
        req_q[port_index_i[IDX_W-1:0]] <= has_cell_i ? fanout_map_i[NUM_OUTPUTS-1:0] : '0;
      end
      if (cmd_i.sched_clear) begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
          taken_q[i] <= '0;
        end
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
          resid_q[o] <= '0;
        end
        total_q  <= '0;
        chosen_q <= '0;
      end
      if (cmd_i.init_acc) begin
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
          resid_q[o] <= resid_q[o] + NT_W'(req_q[in_idx][o]);
        end
        total_q <= total_q + TOT_W'(popcnt(req_q[in_idx]));
      end
      if (cmd_i.fix) begin
        // Requester counts become residues: one requester per output is free.
        for (int o = 0; o < NUM_OUTPUTS; o++) begin
          if (live[o]) begin
            resid_q[o] <= resid_q[o] - 1'b1;
          end
        end
        total_q <= total_q - TOT_W'(popcnt(live));
      end
      if (cmd_i.clear_chosen) begin
        chosen_q <= '0;
      end
      if (cmd_i.mod_start) begin
        lfsr_q <= lfsr_adv;
      end
      if (cmd_i.apply) begin
        taken_q[pick_q][low_bit] <= 1'b1;
        resid_q[low_bit]         <= resid_q[low_bit] - 1'b1;
        total_q                  <= total_q - 1'b1;
        chosen_q[pick_q]         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      age_q[port_index_i[IDX_W-1:0]] <= cell_age_i;
    end
    if (cmd_i.scan_start) begin
      nties_q <= '0;
    end
    if (cmd_i.scan_step && qualify) begin
      if (better) begin
        nties_q     <= NT_W'(1);
        ties_q[0]   <= in_idx;
        least_q     <= common;
        least_age_q <= scan_age;
      end else if (equal) begin
        ties_q[nties_q[IDX_W-1:0]] <= in_idx;
        nties_q <= nties_q + 1'b1;
      end
    end
    if (cmd_i.pick_first) begin
      pick_q <= ties_q[0];
    end
    if (cmd_i.pick_mod) begin
      pick_q <= ties_q[mod_rem];
    end
    if (cmd_i.emit_load) begin
      oidx_q    <= 4'(out_idx);
      granted_q <= col_hit;
      gport_q   <= 4'(col_port);
      glast_q   <= (out_idx == OIDX_W'(NUM_RES - 1));
    end
  end

  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.nties_zero = (nties_q == '0);
  assign sts_o.nties_one  = (nties_q == NT_W'(1));
  assign sts_o.mod_done   = mod_done;

  assign output_index_o = oidx_q;
  assign granted_o      = granted_q;
  assign grant_port_o   = gport_q;
  assign last_grant_o   = glast_q;
endmodule

### hw/rtl/mrs_ctrl.sv
// Controller: sequences loading, residue counting, the picking loop and the result stream.
`timescale 1ns / 1ps
`include "multicast_residue_scheduler_defines.svh"
module mrs_ctrl
  import mrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_port_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  mrs_sts_t sts_i,
  output mrs_cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_FIX    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_MOD    = 4'd6;
  localparam logic [3:0] S_APPLY  = 4'd7;
  localparam logic [3:0] S_ELOAD  = 4'd8;
  localparam logic [3:0] S_EWAIT  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_port_i) begin
            cmd_o.sched_clear = 1'b1;
            idx_d   = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_acc = 1'b1;
        if (idx_q == CNT_W'(NUM_INPUTS - 1)) begin
          idx_d   = '0;
          state_d = S_FIX;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        idx_d = '0;
        if (sts_i.total_zero) begin
          state_d = S_ELOAD;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (idx_q == CNT_W'(NUM_INPUTS - 1)) begin
          idx_d   = '0;
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts_i.nties_zero) begin
          cmd_o.clear_chosen = 1'b1;
          state_d = S_CHECK;
        end else if (sts_i.nties_one) begin
          cmd_o.pick_first = 1'b1;
          state_d = S_APPLY;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.pick_mod = 1'b1;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_CHECK;
      end
      S_ELOAD: begin
        cmd_o.emit_load = 1'b1;
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_ready_i) begin
          if (idx_q == CNT_W'(NUM_RES - 1)) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_ELOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EWAIT);

  `MRS_ASSERT(a_no_in_while_out, !(in_ready_o && out_valid_o))
  `MRS_ASSERT(a_mod_waits, (state_q == S_MOD && !sts_i.mod_done) |=> (state_q == S_MOD))
  `MRS_ASSERT(a_last_to_idle, (out_valid_o && out_ready_i && idx_q == CNT_W'(NUM_RES - 1)) |=> in_ready_o)
  `MRS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE))
endmodule

### hw/rtl/multicast_residue_scheduler.sv
// Top level of the multicast residue scheduler: controller, datapath and ports.
// Usage: present one transaction per input port on the in_* channel (port_index,
// has_cell, fanout_map, cell_age). A transaction without last_port is only stored.
// A transaction with last_port stores its port and starts the schedule; the input
// channel then stays not ready until all results are delivered.
// Scheduling first counts the requesters of each output over all inputs, then forms
// residues, then loops in passes: a check state, a scan over all inputs and a decide
// state, plus an apply state when an input is picked; a pass with no candidate only
// clears the chosen flags. When several inputs tie, a pick also waits for the serial
// remainder unit. Each pass either removes one residue or clears the chosen flags,
// so at most two passes per residue unit are needed.
// Results follow as NUM_RES transactions, output 0 first, each loaded into the
// result register before it is offered; last_grant marks the final one. A stalled
// receiver simply holds the result, which stays unchanged until out_ready_i is seen.
// The cfg channel is always ready and loads the LFSR seed; write it only while idle.
// Reset clears request rows, residues and flags and sets the LFSR to one.
`timescale 1ns / 1ps
module multicast_residue_scheduler
  import mrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  port_index_i,
  input  logic        has_cell_i,
  input  logic [15:0] fanout_map_i,
  input  logic [31:0] cell_age_i,
  input  logic        last_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  output_index_o,
  output logic        granted_o,
  output logic [3:0]  grant_port_o,
  output logic        last_grant_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_lfsr_seed_i
);
  mrs_cmd_t cmd;
  mrs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_port_i (last_port_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .port_index_i    (port_index_i),
    .has_cell_i      (has_cell_i),
    .fanout_map_i    (fanout_map_i),
    .cell_age_i      (cell_age_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_lfsr_seed_i (cfg_lfsr_seed_i),
    .output_index_o  (output_index_o),
    .granted_o       (granted_o),
    .grant_port_o    (grant_port_o),
    .last_grant_o    (last_grant_o)
  );
endmodule
